// File: src/frame_rotate_flip_defines.svh
// Assertion macros shared by the frame rotator checker.
// Every macro assumes signals named clk and arst_n in the using scope.
`ifndef FRAME_ROTATE_FLIP_DEFINES_SVH
`define FRAME_ROTATE_FLIP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FRF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/frf_pkg.sv
// Shared types, sizes and codes for the frame rotator.
// Used by every module of the block but frf_ram; depends on nothing.
package frf_pkg;

	// Largest frame side and the sizes that follow from it.
	localparam int MAX_DIM    = 256;
	localparam int CNT_W      = $clog2(MAX_DIM);
	localparam int DIM_W      = CNT_W + 1;
	localparam int ADDR_W     = 2 * CNT_W;
	localparam int BANK_DEPTH = MAX_DIM * MAX_DIM;
	localparam int RAM_DEPTH  = 2 * BANK_DEPTH;

	// Configuration register widths, reset values and indexes.
	localparam int CFG_DIM_W  = 9;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int CMP_W      = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
	localparam logic [CFG_DIM_W-1:0] DIM_RESET = CFG_DIM_W'(256);

	localparam logic [CFG_IDX_W-1:0] REG_ROTATE_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	// Rotation modes; any other code rotates anticlockwise.
	localparam logic [MODE_W-1:0] MODE_CW90     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ROT180   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MIRROR_H = 3'd2;
	localparam logic [MODE_W-1:0] MODE_MIRROR_V = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ACW90    = 3'd4;

	// Queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int PIX_W = 24;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} src_pix_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       out_valid;
		logic       frame_end;
	} dst_pix_t;

	// Front stage: operands of the write address still to be combined.
	typedef struct packed {
		logic [PIX_W-1:0]  pixel;
		logic [ADDR_W-1:0] mul_a;
		logic [ADDR_W-1:0] mul_b;
		logic [ADDR_W-1:0] add_c;
		logic [ADDR_W-1:0] rd_addr;
		logic              fill_bank;
		logic              ready;
		logic              frame_last;
	} front_s1_t;

	// One classified item waiting for the frame store.
	typedef struct packed {
		logic [PIX_W-1:0]  pixel;
		logic [ADDR_W-1:0] wr_addr;
		logic [ADDR_W-1:0] rd_addr;
		logic              fill_bank;
		logic              ready;
		logic              frame_last;
	} q_entry_t;

	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_status_t;

endpackage

// File: src/frf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Stands alone; sized by its parameters.
module frf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read ports; read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/frf_front.sv
// Front part of the frame rotator: configuration, raster counters and
// write-address calculation. Uses frf_pkg; feeds frf_queue.
module frf_front
	import frf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  src_pix_t              src_pixel,
	input  q_status_t             q_stat,
	output logic                  push,
	output q_entry_t              push_entry
);

	logic [MODE_W-1:0]    mode_q;
	logic [CFG_DIM_W-1:0] width_q;
	logic [CFG_DIM_W-1:0] height_q;
	logic [CNT_W-1:0]     col_q;
	logic [CNT_W-1:0]     row_q;
	logic [ADDR_W-1:0]    lin_q;
	logic                 fill_q;
	logic                 ready_q;
	logic                 v_s1;
	front_s1_t            d_s1;

	logic [DIM_W-1:0]     w;
	logic [DIM_W-1:0]     h;
	logic [ADDR_W-1:0]    xe;
	logic [ADDR_W-1:0]    ye;
	logic [ADDR_W-1:0]    we_ext;
	logic [ADDR_W-1:0]    he_ext;
	logic [ADDR_W-1:0]    xm;
	logic [ADDR_W-1:0]    ym;
	logic [ADDR_W-1:0]    op_a;
	logic [ADDR_W-1:0]    op_b;
	logic [ADDR_W-1:0]    op_c;
	logic                 line_last;
	logic                 frame_last;
	logic                 accept;
	logic [QCNT_W:0]      pending;

	// Zero is used as one and oversize as the largest side.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
		logic [CMP_W-1:0] ve;
		logic [DIM_W-1:0] r;
		ve = CMP_W'(v);
		if (ve == '0) begin
			r = DIM_W'(1);
		end else if (ve > CMP_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = ve[DIM_W-1:0];
		end
		return r;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_CW90;
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROTATE_MODE:  mode_q   <= cfg_data[MODE_W-1:0];
				REG_FRAME_WIDTH:  width_q  <= cfg_data[CFG_DIM_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[CFG_DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Room is reserved for the item in the stage and one more.
	assign pending   = (QCNT_W + 1)'(q_stat.count) + (QCNT_W + 1)'(v_s1);
	assign src_stall = pending >= (QCNT_W + 1)'(QDEPTH);
	assign accept    = src_valid && !src_stall;

	// Position classification and multiplier operands per mode.
	always_comb begin
		w          = clamp_dim(width_q);
		h          = clamp_dim(height_q);
		xe         = ADDR_W'(col_q);
		ye         = ADDR_W'(row_q);
		we_ext     = ADDR_W'(w);
		he_ext     = ADDR_W'(h);
		xm         = we_ext - ADDR_W'(1) - xe;
		ym         = he_ext - ADDR_W'(1) - ye;
		line_last  = (DIM_W'(col_q) + DIM_W'(1)) >= w;
		frame_last = line_last && ((DIM_W'(row_q) + DIM_W'(1)) >= h);
		unique case (mode_q)
			MODE_CW90: begin
				op_a = xe;
				op_b = he_ext;
				op_c = ym;
			end
			MODE_ROT180: begin
				op_a = ym;
				op_b = we_ext;
				op_c = xm;
			end
			MODE_MIRROR_H: begin
				op_a = ye;
				op_b = we_ext;
				op_c = xm;
			end
			MODE_MIRROR_V: begin
				op_a = ym;
				op_b = we_ext;
				op_c = xe;
			end
			default: begin
				op_a = xm;
				op_b = he_ext;
				op_c = ye;
			end
		endcase
	end

	// Raster counters and bank state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			lin_q   <= '0;
			fill_q  <= 1'b0;
			ready_q <= 1'b0;
		end else if (accept) begin
			if (frame_last) begin
				col_q   <= '0;
				row_q   <= '0;
				lin_q   <= '0;
				fill_q  <= ~fill_q;
				ready_q <= 1'b1;
			end else if (line_last) begin
				col_q <= '0;
				row_q <= row_q + CNT_W'(1);
				lin_q <= lin_q + ADDR_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
				lin_q <= lin_q + ADDR_W'(1);
			end
		end
	end

	// Stage register ahead of the address multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			d_s1.pixel      <= src_pixel;
			d_s1.mul_a      <= op_a;
			d_s1.mul_b      <= op_b;
			d_s1.add_c      <= op_c;
			d_s1.rd_addr    <= lin_q;
			d_s1.fill_bank  <= fill_q;
			d_s1.ready      <= ready_q;
			d_s1.frame_last <= frame_last;
		end
	end

	// Write address modulo the bank depth, then into the queue.
	assign push                  = v_s1;
	assign push_entry.pixel      = d_s1.pixel;
	assign push_entry.wr_addr    = d_s1.mul_a * d_s1.mul_b + d_s1.add_c;
	assign push_entry.rd_addr    = d_s1.rd_addr;
	assign push_entry.fill_bank  = d_s1.fill_bank;
	assign push_entry.ready      = d_s1.ready;
	assign push_entry.frame_last = d_s1.frame_last;

endmodule

// File: src/frf_queue.sv
// Short queue of classified items between front and back.
// Uses frf_pkg for the entry and status types.
module frf_queue
	import frf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_entry,
	input  logic      pop,
	output q_entry_t  head,
	output q_status_t stat
);

	q_entry_t          ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head       = ent_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

// File: src/frf_back.sv
// Back part of the frame rotator: frame store access and the result register.
// Uses frf_pkg and frf_ram; takes items from frf_queue.
module frf_back
	import frf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t q_stat,
	input  q_entry_t  head,
	output logic      pop,
	output logic      dst_valid,
	input  logic      dst_stall,
	output dst_pix_t  dst_pixel
);

	localparam int RAM_AW = $clog2(RAM_DEPTH);

	logic             rd_v_s1;
	logic             ready_s1;
	logic             last_s1;
	logic             dst_v_q;
	dst_pix_t         dst_q;
	logic [PIX_W-1:0] rdata;
	logic             dst_free;
	logic             advance;

	// The result register can load when it is empty or its item leaves now.
	// The read stage moves on when it is empty or can hand over to the result.
	assign dst_free = !dst_v_q || !dst_stall;
	assign advance  = !rd_v_s1 || dst_free;
	assign pop      = advance && !q_stat.empty;

	// Both banks in one store; the bank bit is the top address bit.
	frf_ram #(
		.WIDTH(PIX_W),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (pop),
		.waddr(RAM_AW'({head.fill_bank, head.wr_addr})),
		.wdata(head.pixel),
		.re   (pop),
		.raddr(RAM_AW'({~head.fill_bank, head.rd_addr})),
		.rdata(rdata)
	);

	// Read stage and result register valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			dst_v_q <= 1'b0;
		end else begin
			if (advance) begin
				rd_v_s1 <= pop;
			end
			if (dst_free) begin
				dst_v_q <= rd_v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ready_s1 <= head.ready;
			last_s1  <= head.frame_last;
		end
	end

	// Result fields are zero until a whole frame is stored.
	always_ff @(posedge clk) begin
		if (dst_free && rd_v_s1) begin
			dst_q.red_out   <= ready_s1 ? rdata[23:16] : 8'd0;
			dst_q.green_out <= ready_s1 ? rdata[15:8] : 8'd0;
			dst_q.blue_out  <= ready_s1 ? rdata[7:0] : 8'd0;
			dst_q.out_valid <= ready_s1;
			dst_q.frame_end <= ready_s1 && last_s1;
		end
	end

	assign dst_valid = dst_v_q;
	assign dst_pixel = dst_q;

endmodule

// File: src/frame_rotate_flip.sv
// Frame rotator / mirror, top level: front, queue and back.
// Uses frf_pkg, frf_front, frf_queue and frf_back.
//
// Pixels enter in raster order and are written into a double-buffered frame
// store at their rotated or mirrored place; each accepted pixel returns one
// pixel of the previous frame in output raster order, so the block takes
// and gives one item per clock when the output side keeps up. An accepted
// item passes the address stage, the queue and the store read into the
// result register; the rate is set by the store's single write port and
// single read port, each used once per item. A four-entry queue parts the
// front from the store so that either side may stall. Results carry zero
// pixels and out_valid low until a full frame has been stored.
// Configuration must only be written while no item is in flight.
module frame_rotate_flip
	import frf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  src_valid,
	output logic                  src_stall,
	input  src_pix_t              src_pixel,
	output logic                  dst_valid,
	input  logic                  dst_stall,
	output dst_pix_t              dst_pixel
);

	logic      push;
	logic      pop;
	q_entry_t  push_entry;
	q_entry_t  head;
	q_status_t q_stat;

	frf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_pixel (src_pixel),
		.q_stat    (q_stat),
		.push      (push),
		.push_entry(push_entry)
	);

	frf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	frf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head     (head),
		.pop      (pop),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_pixel(dst_pixel)
	);

endmodule

// File: src/frf_checker.sv
// Port-level checks of the frame rotator, bound to the top level.
// Uses frf_pkg and the macros of frame_rotate_flip_defines.svh.
`include "frame_rotate_flip_defines.svh"

module frf_checker
	import frf_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     dst_valid,
	input logic     dst_stall,
	input dst_pix_t dst_pixel
);

	// A held result stays in place.
	`FRF_ASSERT_NEXT(a_dst_hold, dst_valid && dst_stall, dst_valid && $stable(dst_pixel), "result changed while stalled")

	// Before a whole frame is stored, results carry zeros and no frame end.
	`FRF_ASSERT_NOW(a_not_ready_zero, dst_valid && !dst_pixel.out_valid, dst_pixel.frame_end == 1'b0 && dst_pixel.red_out == 8'd0 && dst_pixel.green_out == 8'd0 && dst_pixel.blue_out == 8'd0, "nonzero result before frame ready")

	// Once a stored frame is shown, every later result is valid too.
	`FRF_ASSERT_NEXT(a_ready_sticky, dst_valid && !dst_stall && dst_pixel.out_valid, !(dst_valid && !dst_pixel.out_valid), "out_valid dropped after a frame was ready")

endmodule

bind frame_rotate_flip frf_checker u_frf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.dst_valid(dst_valid),
	.dst_stall(dst_stall),
	.dst_pixel(dst_pixel)
);
